// ----- sv/rdpd_pkg.sv -----
// Shared constants, types and helper functions of the row dither pixel detector.
`default_nettype none

package rdpd_pkg;

    localparam int WINDOW_LEN_DEF   = 8;
    localparam int NUM_CHANNELS_DEF = 3;
    // Number of channel fields that a pixel beat carries.
    localparam int NF               = 3;
    localparam int PIX_W            = 16;
    localparam int THR_W            = 15;
    localparam logic [THR_W-1:0] THR_RESET = 15'd1920;
    // Must be a power of two of at least two.
    localparam int QUEUE_DEPTH      = 2;

    typedef logic [PIX_W-1:0] pix_t;

    // One unit of work for the back end: an optional verdict for the held
    // pixel, optionally followed by the end-of-row result.
    typedef struct packed {
        logic            has_judge;
        logic            has_end;
        pix_t [NF-1:0]   pd;
        pix_t [NF-1:0]   pr;
        pix_t [NF-1:0]   dx;
        pix_t [NF-1:0]   diff;
    } job_t;

    function automatic pix_t abs_diff(input pix_t a, input pix_t b);
        logic signed [PIX_W:0] d;
        d = $signed({a[PIX_W-1], a}) - $signed({b[PIX_W-1], b});
        if (d < 0)
        begin
            d = -d;
        end
        return d[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/rdpd_pix_if.sv -----
// Pixel input channel: reference and distorted Lab values plus the row end mark.
`default_nettype none

interface rdpd_pix_if;
    logic                               valid;
    logic                               ready;
    logic signed [rdpd_pkg::PIX_W-1:0]  ref_l;
    logic signed [rdpd_pkg::PIX_W-1:0]  ref_a;
    logic signed [rdpd_pkg::PIX_W-1:0]  ref_b;
    logic signed [rdpd_pkg::PIX_W-1:0]  dist_l;
    logic signed [rdpd_pkg::PIX_W-1:0]  dist_a;
    logic signed [rdpd_pkg::PIX_W-1:0]  dist_b;
    logic                               row_end;

    modport source (
        output valid, ref_l, ref_a, ref_b, dist_l, dist_a, dist_b, row_end,
        input  ready
    );
    modport sink (
        input  valid, ref_l, ref_a, ref_b, dist_l, dist_a, dist_b, row_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/rdpd_res_if.sv -----
// Verdict output channel: the dither flag and the end-of-row mark.
`default_nettype none

interface rdpd_res_if;
    logic valid;
    logic ready;
    logic flagged;
    logic last_of_row;

    modport source (
        output valid, flagged, last_of_row,
        input  ready
    );
    modport sink (
        input  valid, flagged, last_of_row,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/rdpd_front.sv -----
// Front end: accepts pixel beats, holds the previous pixel and forms jobs.
`default_nettype none

module rdpd_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    rdpd_pix_if.sink          pixel,
    output logic              job_valid,
    input  wire logic         job_ready,
    output rdpd_pkg::job_t    job,
    output logic              pending
);

    logic            pending_reg;
    logic            pending_next;
    rdpd_pkg::pix_t  pd_reg [rdpd_pkg::NF];
    rdpd_pkg::pix_t  pr_reg [rdpd_pkg::NF];
    rdpd_pkg::pix_t  cur_ref [rdpd_pkg::NF];
    rdpd_pkg::pix_t  cur_dist [rdpd_pkg::NF];
    logic            accept;

    always_comb
    begin
        cur_ref[0]  = pixel.ref_l;
        cur_ref[1]  = pixel.ref_a;
        cur_ref[2]  = pixel.ref_b;
        cur_dist[0] = pixel.dist_l;
        cur_dist[1] = pixel.dist_a;
        cur_dist[2] = pixel.dist_b;

        pixel.ready = job_ready;
        accept      = pixel.valid && job_ready;

        // The held pixel is judged against the arriving one.
        job.has_judge = pending_reg;
        job.has_end   = pixel.row_end;
        for (int c = 0; c < rdpd_pkg::NF; c++)
        begin
            job.pd[c]   = pd_reg[c];
            job.pr[c]   = pr_reg[c];
            job.dx[c]   = rdpd_pkg::abs_diff(cur_dist[c], pd_reg[c]);
            job.diff[c] = rdpd_pkg::abs_diff(pd_reg[c], pr_reg[c]);
        end

        job_valid    = accept && (pending_reg || pixel.row_end);
        pending_next = accept ? !pixel.row_end : pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !pixel.row_end)
        begin
            for (int c = 0; c < rdpd_pkg::NF; c++)
            begin
                pd_reg[c] <= cur_dist[c];
                pr_reg[c] <= cur_ref[c];
            end
        end
    end

    assign pending = pending_reg;

endmodule

`default_nettype wire

// ----- sv/rdpd_queue.sv -----
// Short job queue between the front end and the back end.
`default_nettype none

module rdpd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire rdpd_pkg::job_t  push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output rdpd_pkg::job_t       pop_data
);

    localparam int AW = $clog2(rdpd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rdpd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(rdpd_pkg::QUEUE_DEPTH);

    rdpd_pkg::job_t  slot_reg [rdpd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    always_comb
    begin
        push_ready  = (count_reg != FULL_COUNT);
        pop_valid   = (count_reg != '0);
        pop_data    = slot_reg[rd_ptr_reg];
        push        = push_valid && push_ready;
        pop         = pop_valid && pop_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rdpd_back.sv -----
// Back end: window sums, verdict compare and the output register.
`default_nettype none

module rdpd_back #(
    parameter int WINDOW_LEN   = rdpd_pkg::WINDOW_LEN_DEF,
    parameter int NUM_CHANNELS = rdpd_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [rdpd_pkg::THR_W-1:0] thr,
    input  wire logic                       job_valid,
    output logic                            job_ready,
    input  wire rdpd_pkg::job_t             job,
    rdpd_res_if.source                      verdict
);

    localparam int NCH = (NUM_CHANNELS < rdpd_pkg::NF) ? NUM_CHANNELS : rdpd_pkg::NF;
    localparam int CLW = $clog2(WINDOW_LEN);
    localparam int HW  = (CLW > 0) ? CLW : 1;
    localparam int MW  = $clog2(WINDOW_LEN + 1);
    localparam int VSW = rdpd_pkg::PIX_W + CLW + 1;
    localparam int GSW = rdpd_pkg::PIX_W + CLW;
    localparam int PW  = VSW + MW + 2;
    localparam logic [MW-1:0] M_FULL = MW'(WINDOW_LEN);
    localparam logic [HW-1:0] H_LAST = HW'(WINDOW_LEN - 1);

    // Row state.
    logic [HW-1:0]          head_reg;
    logic [HW-1:0]          head_next;
    logic [MW-1:0]          cnt_reg;
    logic [MW-1:0]          cnt_next;
    logic signed [VSW-1:0]  vsum_reg [NCH];
    logic signed [VSW-1:0]  vsum_next [NCH];
    logic [GSW-1:0]         gsum_reg [NCH];
    logic [GSW-1:0]         gsum_next [NCH];
    rdpd_pkg::pix_t         vwin_reg [NCH][WINDOW_LEN];
    rdpd_pkg::pix_t         gwin_reg [NCH][WINDOW_LEN];

    // Compare stage.
    logic                   a_valid_reg;
    logic                   a_valid_next;
    logic                   a_judge_reg;
    logic                   a_end_reg;
    logic [MW-1:0]          a_m_reg;
    logic signed [VSW-1:0]  a_vsum_reg [NCH];
    logic [GSW-1:0]         a_gsum_reg [NCH];
    rdpd_pkg::pix_t         a_pr_reg [NCH];
    rdpd_pkg::pix_t         a_dx_reg [NCH];
    rdpd_pkg::pix_t         a_diff_reg [NCH];

    // Output register.
    logic                   out_valid_reg;
    logic                   flag_reg;
    logic                   last_reg;
    logic                   end_pend_reg;

    logic                   full;
    logic [MW-1:0]          m_cur;
    logic [HW-1:0]          head_inc;
    logic signed [VSW-1:0]  vs_new [NCH];
    logic [GSW-1:0]         gs_new [NCH];
    logic                   a_load;
    logic                   a_take;
    logic                   load_ok;
    logic [PW-1:0]          p_diff [NCH];
    logic [PW-1:0]          p_grad [NCH];
    logic signed [PW-1:0]   p_ref [NCH];
    logic signed [PW-1:0]   dev [NCH];
    logic [PW-1:0]          dev_abs [NCH];
    logic                   hit;

    always_comb
    begin
        load_ok   = !out_valid_reg || verdict.ready;
        a_take    = a_valid_reg && load_ok && !end_pend_reg;
        job_ready = !a_valid_reg || a_take;
        a_load    = job_valid && job_ready;
        a_valid_next = a_load ? 1'b1 : (a_take ? 1'b0 : a_valid_reg);

        full     = (cnt_reg >= M_FULL);
        m_cur    = full ? M_FULL : cnt_reg + 1'b1;
        head_inc = (head_reg == H_LAST) ? '0 : head_reg + 1'b1;

        // Once the window is full, the oldest entry sits at the head.
        for (int c = 0; c < NCH; c++)
        begin
            vs_new[c] = vsum_reg[c] + VSW'($signed(job.pd[c]))
                        - (full ? VSW'($signed(vwin_reg[c][head_reg])) : '0);
            gs_new[c] = gsum_reg[c] + GSW'(job.dx[c])
                        - (full ? GSW'(gwin_reg[c][head_reg]) : '0);
        end

        head_next = head_reg;
        cnt_next  = cnt_reg;
        for (int c = 0; c < NCH; c++)
        begin
            vsum_next[c] = vsum_reg[c];
            gsum_next[c] = gsum_reg[c];
        end
        if (a_load && job.has_judge)
        begin
            head_next = head_inc;
            cnt_next  = m_cur;
            for (int c = 0; c < NCH; c++)
            begin
                vsum_next[c] = vs_new[c];
                gsum_next[c] = gs_new[c];
            end
        end
        if (a_load && job.has_end)
        begin
            head_next = '0;
            cnt_next  = '0;
            for (int c = 0; c < NCH; c++)
            begin
                vsum_next[c] = '0;
                gsum_next[c] = '0;
            end
        end
    end

    // Means are compared by scaling the pixel terms with the entry count.
    always_comb
    begin
        hit = 1'b0;
        for (int c = 0; c < NCH; c++)
        begin
            p_diff[c]  = PW'(a_diff_reg[c]) * PW'(a_m_reg);
            p_grad[c]  = PW'(a_dx_reg[c]) * PW'(a_m_reg);
            p_ref[c]   = PW'($signed(a_pr_reg[c])) * $signed(PW'(a_m_reg));
            dev[c]     = PW'(a_vsum_reg[c]) - p_ref[c];
            dev_abs[c] = (dev[c] < 0) ? PW'(-dev[c]) : PW'(dev[c]);
            if ((a_diff_reg[c] >= {1'b0, thr}) &&
                (p_diff[c] >= dev_abs[c]) &&
                (p_grad[c] >= PW'(a_gsum_reg[c])))
            begin
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                vsum_reg[c] <= '0;
                gsum_reg[c] <= '0;
            end
            a_valid_reg   <= 1'b0;
            a_judge_reg   <= 1'b0;
            a_end_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= 1'b0;
            last_reg      <= 1'b0;
            end_pend_reg  <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
            for (int c = 0; c < NCH; c++)
            begin
                vsum_reg[c] <= vsum_next[c];
                gsum_reg[c] <= gsum_next[c];
            end
            a_valid_reg <= a_valid_next;
            if (a_load)
            begin
                a_judge_reg <= job.has_judge;
                a_end_reg   <= job.has_end;
            end
            // A job with both parts gives two beats; the row end beat follows.
            if (load_ok)
            begin
                if (end_pend_reg)
                begin
                    out_valid_reg <= 1'b1;
                    flag_reg      <= 1'b0;
                    last_reg      <= 1'b1;
                    end_pend_reg  <= 1'b0;
                end
                else if (a_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    if (a_judge_reg)
                    begin
                        flag_reg     <= hit;
                        last_reg     <= 1'b0;
                        end_pend_reg <= a_end_reg;
                    end
                    else
                    begin
                        flag_reg     <= 1'b0;
                        last_reg     <= 1'b1;
                        end_pend_reg <= 1'b0;
                    end
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_m_reg <= m_cur;
            for (int c = 0; c < NCH; c++)
            begin
                a_vsum_reg[c] <= vs_new[c];
                a_gsum_reg[c] <= gs_new[c];
                a_pr_reg[c]   <= job.pr[c];
                a_dx_reg[c]   <= job.dx[c];
                a_diff_reg[c] <= job.diff[c];
            end
        end
        if (a_load && job.has_judge)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                vwin_reg[c][head_reg] <= job.pd[c];
                gwin_reg[c][head_reg] <= job.dx[c];
            end
        end
    end

    assign verdict.valid       = out_valid_reg;
    assign verdict.flagged     = flag_reg;
    assign verdict.last_of_row = last_reg;

endmodule

`default_nettype wire

// ----- sv/row_dither_pixel_detector.sv -----
// Row dither pixel detector top level: threshold register, front end, job queue and back end.
`default_nettype none

// Takes one pixel beat per clock and gives each pixel's dither verdict when the
// next pixel of the row arrives; a beat with row_end set also yields a verdict
// of zero marked last_of_row, so when a pixel is held that beat produces two
// result beats, which the output port sends one right after the other, with no
// other beat between them. The input side keeps taking one beat per cycle as
// long as the two-entry job queue has room. A job passes from the queue into the
// compare stage, where the window sums update as it is loaded, and its compare
// result is then registered in the output register; a stall can hold either step.
// Window sums restart at every row. The user must write diff_threshold through
// cfg_we and cfg_wdata only while the block is idle; the block does not enforce it.
module row_dither_pixel_detector #(
    parameter int WINDOW_LEN   = rdpd_pkg::WINDOW_LEN_DEF,
    parameter int NUM_CHANNELS = rdpd_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [rdpd_pkg::THR_W-1:0] cfg_wdata,
    rdpd_pix_if.sink                        pixel,
    rdpd_res_if.source                      verdict
);

    logic [rdpd_pkg::THR_W-1:0] diff_threshold_reg;
    logic [rdpd_pkg::THR_W-1:0] diff_threshold_next;

    logic            push_valid;
    logic            push_ready;
    rdpd_pkg::job_t  push_job;
    logic            pop_valid;
    logic            pop_ready;
    rdpd_pkg::job_t  pop_job;
    logic            front_pending;

    always_comb
    begin
        diff_threshold_next = cfg_we ? cfg_wdata : diff_threshold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_threshold_reg <= rdpd_pkg::THR_RESET;
        end
        else
        begin
            diff_threshold_reg <= diff_threshold_next;
        end
    end

    rdpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job),
        .pending   (front_pending)
    );

    rdpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    rdpd_back #(
        .WINDOW_LEN   (WINDOW_LEN),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (diff_threshold_reg),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .verdict   (verdict)
    );

    // The row end beat never carries a dither flag.
    a_last_unflagged: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.last_of_row) |-> !verdict.flagged)
        else $error("row end verdict is flagged");

    // After a pixel beat, a pixel is held exactly when that beat did not end the row.
    a_hold_follows_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> (front_pending == !$past(pixel.row_end)))
        else $error("held pixel state does not follow row end");

    // Every queued job produces at least one result.
    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |-> (push_job.has_judge || push_job.has_end))
        else $error("empty job pushed");

endmodule

`default_nettype wire

// ----- test/row_dither_pixel_detector_test.sv -----
// Testbench of the row dither pixel detector: predicted verdicts checked beat by beat.
`timescale 1ns / 100ps
`default_nettype none

module row_dither_pixel_detector_test;

    localparam int NF         = rdpd_pkg::NF;
    localparam int PIX_W      = rdpd_pkg::PIX_W;
    localparam int THR_W      = rdpd_pkg::THR_W;
    localparam logic [THR_W-1:0] THR_RESET = rdpd_pkg::THR_RESET;
    localparam int WIN        = rdpd_pkg::WINDOW_LEN_DEF;
    localparam int CHANNELS   = (rdpd_pkg::NUM_CHANNELS_DEF < NF) ?
                                rdpd_pkg::NUM_CHANNELS_DEF : NF;
    localparam int LONG_HOLD  = 80;
    localparam int PHASE_BEATS = 220;
    localparam int EXP_DEPTH  = 256;

    typedef struct packed {
        logic signed [PIX_W-1:0] ref_l;
        logic signed [PIX_W-1:0] ref_a;
        logic signed [PIX_W-1:0] ref_b;
        logic signed [PIX_W-1:0] dist_l;
        logic signed [PIX_W-1:0] dist_a;
        logic signed [PIX_W-1:0] dist_b;
        logic                    row_end;
    } pixel_t;

    typedef struct {
        logic flagged;
        logic last_of_row;
    } verdict_t;

    typedef enum int {
        ROW_NOISE,
        ROW_DITHER,
        ROW_BROKEN
    } row_style_t;

    class verdict_checker_t;
        logic [THR_W-1:0] threshold;
        int held_dist[NF];
        int held_ref[NF];
        int value_win[NF][WIN];
        int grad_win[NF][WIN];
        int value_sum[NF];
        int grad_sum[NF];
        int fill;
        int head;
        bit held;
        verdict_t expected_q[EXP_DEPTH];
        int exp_rd;
        int exp_count;
        int errors;

        function new();
            threshold = THR_RESET;
            errors = 0;
            exp_rd = 0;
            exp_count = 0;
            for (int c = 0; c < NF; c++)
            begin
                held_dist[c] = 0;
                held_ref[c] = 0;
            end
            clear_row();
        endfunction

        function void clear_row();
            for (int c = 0; c < NF; c++)
            begin
                value_sum[c] = 0;
                grad_sum[c] = 0;
                for (int k = 0; k < WIN; k++)
                begin
                    value_win[c][k] = 0;
                    grad_win[c][k] = 0;
                end
            end
            fill = 0;
            head = 0;
            held = 0;
        endfunction

        function int outstanding();
            return exp_count;
        endfunction

        function void add_expected(verdict_t v);
            if (exp_count >= EXP_DEPTH)
            begin
                $error("too many predicted verdicts outstanding");
                errors++;
                return;
            end
            expected_q[(exp_rd + exp_count) % EXP_DEPTH] = v;
            exp_count++;
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        // Folds the held pixel into the windows and decides whether it dithers.
        function logic judge_held(int next_dist[NF]);
            bit full;
            int m;
            int pd, pr, dx, diff, dev_mag;
            logic hit;
            full = (fill >= WIN);
            m = full ? WIN : fill + 1;
            hit = 1'b0;
            if (head >= WIN)
            begin
                head = 0;
            end
            for (int c = 0; c < CHANNELS; c++)
            begin
                pd = held_dist[c];
                pr = held_ref[c];
                dx = magnitude(next_dist[c] - pd);
                if (full)
                begin
                    value_sum[c] -= value_win[c][head];
                    grad_sum[c] -= grad_win[c][head];
                end
                value_win[c][head] = pd;
                grad_win[c][head] = dx;
                value_sum[c] += pd;
                grad_sum[c] += dx;
                diff = magnitude(pd - pr);
                dev_mag = magnitude(value_sum[c] - pr * m);
                if (diff >= int'(threshold) && diff * m >= dev_mag &&
                    dx * m >= grad_sum[c])
                begin
                    hit = 1'b1;
                end
            end
            head = (head + 1 >= WIN) ? 0 : head + 1;
            fill = m;
            return hit;
        endfunction

        function void note_pixel(pixel_t p);
            int cur_ref[NF];
            int cur_dist[NF];
            verdict_t v;
            cur_ref[0] = int'(p.ref_l);
            cur_ref[1] = int'(p.ref_a);
            cur_ref[2] = int'(p.ref_b);
            cur_dist[0] = int'(p.dist_l);
            cur_dist[1] = int'(p.dist_a);
            cur_dist[2] = int'(p.dist_b);
            if (held)
            begin
                v.flagged = judge_held(cur_dist);
                v.last_of_row = 1'b0;
                add_expected(v);
            end
            if (p.row_end)
            begin
                v.flagged = 1'b0;
                v.last_of_row = 1'b1;
                add_expected(v);
                clear_row();
            end
            else
            begin
                held_dist = cur_dist;
                held_ref = cur_ref;
                held = 1;
            end
        endfunction

        function void check_verdict(logic flagged, logic last_of_row);
            verdict_t want;
            if (exp_count == 0)
            begin
                $error("unexpected verdict beat: flagged %b last_of_row %b",
                       flagged, last_of_row);
                errors++;
                return;
            end
            want = expected_q[exp_rd];
            exp_rd = (exp_rd + 1) % EXP_DEPTH;
            exp_count--;
            if (flagged !== want.flagged)
            begin
                $error("flagged: expected %b, actual %b", want.flagged, flagged);
                errors++;
            end
            if (last_of_row !== want.last_of_row)
            begin
                $error("last_of_row: expected %b, actual %b", want.last_of_row, last_of_row);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    rdpd_pix_if pixel();
    rdpd_res_if verdict();

    verdict_checker_t board;

    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_req;

    row_dither_pixel_detector uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .pixel    (pixel),
        .verdict  (verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("row_dither_pixel_detector verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel.valid && pixel.ready)
        begin
            board.note_pixel('{pixel.ref_l, pixel.ref_a, pixel.ref_b,
                               pixel.dist_l, pixel.dist_a, pixel.dist_b, pixel.row_end});
        end
        if (rst_n && verdict.valid && verdict.ready)
        begin
            board.check_verdict(verdict.flagged, verdict.last_of_row);
        end
    end

    // Receiver: short random stalls, or one long hold-off when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        verdict.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                verdict.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left = LONG_HOLD - 1;
                verdict.ready <= 1'b0;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                hold_left = $urandom_range(0, 4);
                verdict.ready <= 1'b0;
            end
            else
            begin
                verdict.ready <= 1'b1;
            end
        end
    end

    function automatic pixel_t px(int rl, int ra, int rb, int dl, int da, int db, bit last);
        pixel_t p;
        p.ref_l = rl[15:0];
        p.ref_a = ra[15:0];
        p.ref_b = rb[15:0];
        p.dist_l = dl[15:0];
        p.dist_a = da[15:0];
        p.dist_b = db[15:0];
        p.row_end = last;
        return p;
    endfunction

    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            pixel.valid <= 1'b0;
        end
    endtask

    task automatic send_pixel(pixel_t p);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            pause_sender($urandom_range(1, 5));
        end
        @(negedge clk);
        pixel.valid <= 1'b1;
        pixel.ref_l <= p.ref_l;
        pixel.ref_a <= p.ref_a;
        pixel.ref_b <= p.ref_b;
        pixel.dist_l <= p.dist_l;
        pixel.dist_a <= p.dist_a;
        pixel.dist_b <= p.dist_b;
        pixel.row_end <= p.row_end;
        do
        begin
            @(posedge clk);
        end
        while (!pixel.ready);
    endtask

    // Stops offering beats until every predicted verdict is out, then lets
    // the pipeline settle before any register write.
    task automatic drain();
        pause_sender(1);
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_threshold(int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[THR_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        board.threshold = value[THR_W-1:0];
    endtask

    task automatic send_row(int len, row_style_t style);
        int base[NF];
        int r[NF];
        int d[NF];
        int amp;
        int mask;
        int raw;
        bit last;
        pixel_t p;
        for (int c = 0; c < NF; c++)
        begin
            raw = $urandom;
            base[c] = int'($signed(raw[15:0]));
        end
        amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30000) : $urandom_range(0, 5000);
        mask = $urandom_range(1, 7);
        for (int k = 0; k < len; k++)
        begin
            last = (k == len - 1);
            if (style == ROW_NOISE)
            begin
                for (int c = 0; c < NF; c++)
                begin
                    r[c] = $urandom;
                    d[c] = $urandom;
                end
            end
            else
            begin
                for (int c = 0; c < NF; c++)
                begin
                    base[c] += $urandom_range(0, 64) - 32;
                    r[c] = base[c];
                    if (mask[c] && $urandom_range(0, 3) != 0)
                    begin
                        d[c] = r[c] + ((k % 2 == 1) ? amp : -amp);
                    end
                    else
                    begin
                        d[c] = r[c] + $urandom_range(0, 200) - 100;
                    end
                end
                if (style == ROW_BROKEN && $urandom_range(0, 5) == 0)
                begin
                    last = 1;
                end
            end
            p = px(r[0], r[1], r[2], d[0], d[1], d[2], last);
            send_pixel(p);
        end
    endtask

    initial
    begin
        int sent;
        int len;
        int pick;
        row_style_t style;

        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pixel.valid = 1'b0;
        pixel.ref_l = '0;
        pixel.ref_a = '0;
        pixel.ref_b = '0;
        pixel.dist_l = '0;
        pixel.dist_a = '0;
        pixel.dist_b = '0;
        pixel.row_end = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_req = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset threshold.
        send_pixel(px(0, 0, 0, 0, 0, 0, 1));
        send_pixel(px(-32768, 32767, -32768, 32767, -32768, 32767, 0));
        send_pixel(px(32767, -32768, 32767, -32768, 32767, -32768, 0));
        send_pixel(px(-32768, -32768, -32768, -32768, -32768, -32768, 1));
        repeat (3) send_pixel(px(100, -100, 5, 100, -100, 5, 0));
        // Dither only in channel a, long enough for the window to wrap.
        for (int k = 0; k < 11; k++)
        begin
            send_pixel(px(0, 0, 0, 0, (k % 2 == 1) ? 3000 : -3000, 0, k == 10));
        end
        // Differences exactly at the threshold.
        send_pixel(px(0, 0, 0, 1920, 0, 0, 0));
        send_pixel(px(0, 0, 0, 0, 0, 0, 0));
        send_pixel(px(0, 0, 0, 1920, 0, 0, 0));
        send_pixel(px(0, 0, 0, 0, 0, 0, 1));

        for (int phase = 0; phase < 7; phase++)
        begin
            drain();
            unique case (phase)
                0:
                begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 15;
                end
                1:
                begin
                    write_threshold(0);
                    tx_idle_pct = 0;
                    rx_idle_pct = 10;
                end
                2:
                begin
                    write_threshold(32767);
                    tx_idle_pct = 15;
                    rx_idle_pct = 40;
                end
                3:
                begin
                    write_threshold($urandom_range(0, 4000));
                    tx_idle_pct = 30;
                end
                4:
                begin
                    write_threshold(1);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                5:
                begin
                    write_threshold($urandom_range(0, 32767));
                    tx_idle_pct = 25;
                end
                default:
                begin
                    write_threshold(1920);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 1 || phase == 4)
            begin
                long_hold_req = 1;
            end
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
                pick = $urandom_range(0, 99);
                style = (pick < 15) ? ROW_NOISE : (pick < 85) ? ROW_DITHER : ROW_BROKEN;
                send_row(len, style);
                sent += len;
            end
        end

        pause_sender(1);
        for (int i = 0; i < 5000 && board.outstanding() != 0; i++)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (board.outstanding() != 0)
        begin
            $error("%0d predicted verdicts never arrived", board.outstanding());
        end
        if (board.errors == 0 && board.outstanding() == 0)
        begin
            $display("row_dither_pixel_detector verification clean");
        end
        else
        begin
            $display("row_dither_pixel_detector verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/rdpd_pkg.sv
sv/rdpd_pix_if.sv
sv/rdpd_res_if.sv
sv/rdpd_front.sv
sv/rdpd_queue.sv
sv/rdpd_back.sv
sv/row_dither_pixel_detector.sv
test/row_dither_pixel_detector_test.sv
